FILE: rtl/fascc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fascc_pkg;

    localparam int AXES         = 5;
    localparam int FRAME_BYTES  = 48;
    localparam int FIELD_DIGITS = 6;
    localparam int CNT_W        = 20;
    localparam int POS_W        = 6;
    localparam int PLACE_W      = 3;
    localparam int FIELD_W      = 3;
    localparam int WEIGHT_W     = 17;
    localparam int DIGIT_W      = 4;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 16;

    localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [AXES-1:0]  ALL_AXES = {AXES{1'b1}};

    // Item classes handed from front to back
    typedef enum logic [2:0] {
        OP_SKIP,
        OP_COMMA,
        OP_MINUS,
        OP_DIGIT,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [DIGIT_W-1:0] digit;
        logic [AXES-1:0]    tick;
        logic               first;
        logic               last;
    } t_cmd;

    // Result word, lowest field in the lowest bits
    typedef struct packed {
        logic            move_done;
        logic            moving;
        logic [AXES-1:0] direction_mask;
        logic [AXES-1:0] running_mask;
    } t_result;

    // Decimal place weight: 10^(FIELD_DIGITS-1-idx), zero past the last place
    function automatic logic [WEIGHT_W-1:0] place_weight(input logic [PLACE_W-1:0] idx);
        logic [PLACE_W-1:0] e;
        logic [WEIGHT_W-1:0] w;
        e = PLACE_W'(FIELD_DIGITS - 1) - idx;
        w = '0;
        if (idx < PLACE_W'(FIELD_DIGITS)) begin
            case (e)
                3'd0:    w = WEIGHT_W'(1);
                3'd1:    w = WEIGHT_W'(10);
                3'd2:    w = WEIGHT_W'(100);
                3'd3:    w = WEIGHT_W'(1000);
                3'd4:    w = WEIGHT_W'(10000);
                3'd5:    w = WEIGHT_W'(100000);
                default: w = '0;
            endcase
        end
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fascc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fascc_front
    import fascc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    input  wire logic [0:0]           i_s_tuser,
    input  wire logic                 i_q_full,
    output logic                      o_push,
    output t_cmd                      o_push_cmd
);

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [7:0]       c;
    logic             is_byte;
    logic             last_byte;

    assign c          = i_s_tdata[7:0];
    assign is_byte    = (i_s_tuser[0] == 1'b0);
    assign last_byte  = (r_pos >= POS_W'(FRAME_BYTES - 1));
    assign o_s_tready = !i_q_full;
    assign o_push     = i_s_tvalid && !i_q_full;

    // classify the byte
    always_comb begin
        o_push_cmd.digit = '0;
        o_push_cmd.tick  = i_s_tdata[8 +: AXES];
        o_push_cmd.first = is_byte && (r_pos == '0);
        o_push_cmd.last  = is_byte && last_byte;
        if (!is_byte) begin
            o_push_cmd.op = OP_TICK;
        end else begin
            unique case (c) inside
                ",":        o_push_cmd.op = OP_COMMA;
                "-":        o_push_cmd.op = OP_MINUS;
                ["0":"9"]: begin
                    o_push_cmd.op    = OP_DIGIT;
                    o_push_cmd.digit = DIGIT_W'(c - 8'h30);
                end
                default:    o_push_cmd.op = OP_SKIP;  // letters, '=', anything else
            endcase
        end
    end

    always_comb begin
        n_pos = r_pos;
        if (o_push && is_byte) begin
            n_pos = last_byte ? '0 : POS_W'(r_pos + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(FRAME_BYTES))
        else $error("frame position out of range");
    a_pos_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && is_byte && last_byte |=> r_pos == '0)
        else $error("frame position did not wrap on last byte");
    a_tick_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && !is_byte |=> r_pos == $past(r_pos))
        else $error("tick moved frame position");
`endif

endmodule

`default_nettype wire

FILE: rtl/fascc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module fascc_queue
    import fascc_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_push_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_head
);

    t_cmd              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_AW:0]     r_count;
    logic              do_pop;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= Q_AW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= Q_AW'(r_rd + 1'b1);
            end
            if (i_push && !do_pop) begin
                r_count <= (Q_AW+1)'(r_count + 1'b1);
            end else if (!i_push && do_pop) begin
                r_count <= (Q_AW+1)'(r_count - 1'b1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        Q_AW'(r_wr - r_rd) == r_count[Q_AW-1:0])
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

FILE: rtl/fascc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fascc_back
    import fascc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_q_valid,
    input  wire t_cmd                 i_q_head,
    output logic                      o_pop,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata
);

    logic [CNT_W-1:0]   r_tgt   [AXES];
    logic [CNT_W-1:0]   n_tgt   [AXES];
    logic [CNT_W-1:0]   r_cnt   [AXES];
    logic [CNT_W-1:0]   n_cnt   [AXES];
    logic [PLACE_W-1:0] r_place [AXES];
    logic [PLACE_W-1:0] n_place [AXES];
    logic [FIELD_W-1:0] r_field;
    logic [FIELD_W-1:0] n_field;
    logic [AXES-1:0]    r_done;
    logic [AXES-1:0]    n_done;
    logic [AXES-1:0]    r_dir;
    logic [AXES-1:0]    n_dir;
    logic               r_active;
    logic               n_active;
    logic               finished;
    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;

    logic [PLACE_W-1:0]         sel_place;
    logic [WEIGHT_W+DIGIT_W-1:0] prod;
    logic                       field_ok;

    assign o_pop      = i_q_valid && (!r_out_valid || i_m_tready);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'(r_out);
    assign field_ok   = (r_field < FIELD_W'(AXES));

    always_comb begin
        sel_place = '0;
        for (int a = 0; a < AXES; a++) begin
            if (r_field == FIELD_W'(a)) begin
                sel_place = i_q_head.first ? '0 : r_place[a];
            end
        end
        prod = i_q_head.digit * place_weight(sel_place);
    end

    always_comb begin
        n_tgt    = r_tgt;
        n_cnt    = r_cnt;
        n_place  = r_place;
        n_field  = r_field;
        n_done   = r_done;
        n_dir    = r_dir;
        n_active = r_active;
        finished = 1'b0;
        if (o_pop) begin
            if (i_q_head.op == OP_TICK) begin
                if (r_active) begin
                    for (int a = 0; a < AXES; a++) begin
                        if (i_q_head.tick[a]) begin
                            if (!r_done[a] && (r_cnt[a] != CNT_MAX)) begin
                                n_cnt[a] = CNT_W'(r_cnt[a] + 1'b1);
                            end
                            if (n_cnt[a] >= r_tgt[a]) begin
                                n_done[a] = 1'b1;
                            end
                        end
                    end
                    if (n_done == ALL_AXES) begin
                        n_active = 1'b0;
                        n_done   = '0;
                        for (int a = 0; a < AXES; a++) begin
                            n_cnt[a] = '0;
                        end
                        finished = 1'b1;
                    end
                end
            end else begin
                // new frame: targets, places and directions start over
                if (i_q_head.first) begin
                    for (int a = 0; a < AXES; a++) begin
                        n_tgt[a]   = '0;
                        n_place[a] = '0;
                    end
                    n_dir = '0;
                end
                if (i_q_head.op == OP_COMMA) begin
                    if (field_ok) begin
                        n_field = FIELD_W'(r_field + 1'b1);
                    end
                end else if (field_ok &&
                             (i_q_head.op == OP_MINUS || i_q_head.op == OP_DIGIT)) begin
                    for (int a = 0; a < AXES; a++) begin
                        if (r_field == FIELD_W'(a)) begin
                            if (i_q_head.op == OP_MINUS) begin
                                n_dir[a] = 1'b1;
                            end else begin
                                n_tgt[a] = n_tgt[a] + prod[CNT_W-1:0];
                            end
                            if (n_place[a] < PLACE_W'(FIELD_DIGITS)) begin
                                n_place[a] = PLACE_W'(n_place[a] + 1'b1);
                            end
                        end
                    end
                end
                if (i_q_head.last) begin
                    n_field = '0;
                    for (int a = 0; a < AXES; a++) begin
                        n_place[a] = '0;
                        n_done[a]  = (n_tgt[a] == '0);
                    end
                    n_active = 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out.running_mask   = n_active ? ~n_done : '0;
        n_out.direction_mask = n_dir;
        n_out.moving         = n_active;
        n_out.move_done      = finished;
    end

    // axis targets, counts and places
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_tgt[a]   <= '0;
                r_cnt[a]   <= '0;
                r_place[a] <= '0;
            end
        end else begin
            r_tgt   <= n_tgt;
            r_cnt   <= n_cnt;
            r_place <= n_place;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field     <= '0;
            r_done      <= '0;
            r_dir       <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_field  <= n_field;
            r_done   <= n_done;
            r_dir    <= n_dir;
            r_active <= n_active;
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> (r_done == '0))
        else $error("done mask set while idle");
    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field <= FIELD_W'(AXES))
        else $error("field index out of range");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.move_done |-> !r_out.moving && (r_out.running_mask == '0))
        else $error("move done reported while moving");
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && finished |=> !r_active)
        else $error("motion still active after finish");
`endif

endmodule

`default_nettype wire

FILE: rtl/five_axis_step_command_controller_core.sv
// Path: an input transfer is written into the command queue, and o_m_tvalid comes from the output register.
// Throughput: one item per cycle while the result side is not stalled; a tick updates every ticked axis at once.
// A four-entry queue between classifier and axis engine absorbs output stalls.
// Reset: synchronous, active low on i_rst_n; clears targets, counts, frame position,
// direction and motion state, and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module five_axis_step_command_controller_core
    import fascc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input stream
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,   // [7:0] command_byte, [12:8] axis_tick_mask
    input  wire logic [0:0]           i_s_tuser,   // [0] kind: 0 command byte, 1 timer tick
    // result stream
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [M_TDATA_W-1:0]      o_m_tdata    // [4:0] running_mask, [9:5] direction_mask,
                                                   // [10] moving, [11] move_done
);

    // front -> queue
    logic q_push;
    t_cmd q_push_cmd;
    logic q_full;

    // queue -> back
    logic q_pop;
    logic q_valid;
    t_cmd q_head;

    // Front end: decodes each byte into a command class and tags frame
    // boundaries (first and last byte) from its own byte-position counter.
    fascc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_push_cmd (q_push_cmd)
    );

    // Short command queue; lets the input keep taking transfers while
    // the result side is stalled.
    fascc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_push_cmd (q_push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_head     (q_head)
    );

    // Back end: accumulates axis targets from digits, runs pulse counting
    // on ticks, and registers one result per command into the output stage.
    fascc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_head   (q_head),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire
